/* rtl/c8wfc_pkg.sv */
// ----------------------------------------------------------------------------
// c8wfc_pkg
// shared types, constants and the crc-8 byte update for the word frame checker
// ----------------------------------------------------------------------------
package c8wfc_pkg;

  localparam int unsigned WORD_LIMIT_DEF = 6;

  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_SEED = 8'hFF;

  // position inside the msb / lsb / crc triplet
  typedef enum logic [1:0] {
    PH_MSB = 2'd0,
    PH_LSB = 2'd1,
    PH_CRC = 2'd2
  } phase_t;

  // one result beat as produced by the checker core
  typedef struct packed {
    logic        valid;
    logic [15:0] data_word;
    logic        status;
    logic        last;
  } result_t;

  localparam logic STATUS_MATCH = 1'b0;
  localparam logic STATUS_ERR   = 1'b1;

  // crc-8, msb first, one byte
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

/* rtl/c8wfc_core.sv */
// ----------------------------------------------------------------------------
// c8wfc_core
// transaction state and crc check, one byte per enabled cycle
// ----------------------------------------------------------------------------
module c8wfc_core
  import c8wfc_pkg::*;
#(
  parameter int unsigned WORD_LIMIT = WORD_LIMIT_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  logic [7:0] rx_byte,
  input  logic       frame_start,
  input  logic [2:0] word_count,
  output result_t    res
);

  localparam int unsigned WLW = $clog2(WORD_LIMIT);
  localparam logic [WLW-1:0] WL_MAX = WLW'(WORD_LIMIT - 1);

  phase_t         phase, phase_next;
  logic [7:0]     high_byte, high_byte_next;
  logic [7:0]     low_byte, low_byte_next;
  logic [7:0]     running_crc, running_crc_next;
  logic [WLW-1:0] words_left, words_left_next;

  always_comb begin
    phase_next       = phase;
    high_byte_next   = high_byte;
    low_byte_next    = low_byte;
    running_crc_next = running_crc;
    words_left_next  = words_left;
    res              = '0;

    if (frame_start) begin
      // saturate oversized counts
      if (32'(word_count) > 32'(WORD_LIMIT - 1)) begin
        words_left_next = WL_MAX;
      end else begin
        words_left_next = WLW'(word_count);
      end
      phase_next       = PH_MSB;
      running_crc_next = CRC_SEED;
    end

    if (words_left_next != '0) begin
      case (phase_next)
        PH_LSB: begin
          low_byte_next    = rx_byte;
          running_crc_next = crc8_update(running_crc_next, rx_byte);
          phase_next       = PH_CRC;
        end
        PH_CRC: begin
          res.valid        = 1'b1;
          phase_next       = PH_MSB;
          if (running_crc_next == rx_byte) begin
            words_left_next = words_left_next - WLW'(1);
            res.data_word   = {high_byte_next, low_byte_next};
            res.status      = STATUS_MATCH;
            res.last        = (words_left_next == '0);
          end else begin
            words_left_next = '0;
            res.status      = STATUS_ERR;
            res.last        = 1'b1;
          end
          running_crc_next = CRC_SEED;
        end
        default: begin
          // msb, also the unused phase code
          high_byte_next   = rx_byte;
          running_crc_next = crc8_update(CRC_SEED, rx_byte);
          phase_next       = PH_LSB;
        end
      endcase
    end

    if (!en) begin
      res.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_MSB;
      high_byte   <= '0;
      low_byte    <= '0;
      running_crc <= CRC_SEED;
      words_left  <= '0;
    end else if (en) begin
      phase       <= phase_next;
      high_byte   <= high_byte_next;
      low_byte    <= low_byte_next;
      running_crc <= running_crc_next;
      words_left  <= words_left_next;
    end
  end

  // an error result always closes the transaction
  assert property (@(posedge clk) disable iff (rst)
    res.valid && res.status == STATUS_ERR |=> words_left == '0)
    else $error("words left after crc error");

  // a result only comes from a crc byte of a running transaction
  assert property (@(posedge clk) disable iff (rst)
    res.valid |-> phase == PH_CRC && !frame_start && words_left != '0)
    else $error("result outside crc phase");

  // a result marked last leaves the block idle
  assert property (@(posedge clk) disable iff (rst)
    res.valid && res.last |=> words_left == '0)
    else $error("block not idle after last result");

  // count never goes past the saturation value
  assert property (@(posedge clk) disable iff (rst)
    words_left <= WL_MAX)
    else $error("words left above limit");

endmodule

/* rtl/crc8_word_frame_checker.sv */
// ----------------------------------------------------------------------------
// crc8_word_frame_checker
// checks crc-8 protected 16-bit words of a sensor read transaction
// ----------------------------------------------------------------------------
// Takes the received bytes of one sensor read, one byte per input beat. The
// beat with frame_start high opens a transaction and carries word_count (values
// of WORD_LIMIT or more saturate to WORD_LIMIT - 1, zero leaves the block idle).
// Bytes come as msb, lsb, crc triplets; the crc-8 (poly 0x31, init 0xff, msb
// first, no final xor) over msb and lsb is compared with the crc byte. A match
// gives one output beat with the word and status 0, last set on the final
// word; a mismatch gives data_word 0, status 1, last 1 and the rest of the
// transaction is dropped. frame_start in mid transaction restarts without a
// result. Bytes outside a transaction produce nothing. Throughput is one byte
// per clock while the output register is free: a byte is held in the input
// register, the crc update and compare are combinational, and the output
// register holds the result until it is taken. A stall on the output only backs
// up into the input once both registers hold a beat.
// ----------------------------------------------------------------------------
module crc8_word_frame_checker
  import c8wfc_pkg::*;
#(
  parameter int unsigned WORD_LIMIT = WORD_LIMIT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  input  logic        frame_start,
  input  logic [2:0]  word_count,
  // output channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] data_word,
  output logic        status,
  output logic        last
);

  // input register
  logic       in_full;
  logic [7:0] in_byte;
  logic       in_start;
  logic [2:0] in_count;

  // a held beat moves on when the output register is free or being emptied
  logic    out_free;
  logic    advance;
  result_t res;

  assign out_free = !out_valid || !out_stall;
  assign advance  = in_full && out_free;
  assign in_stall = in_full && !out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!in_stall) begin
      in_full <= in_valid;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_byte  <= rx_byte;
      in_start <= frame_start;
      in_count <= word_count;
    end
  end

  // transaction state and crc check
  c8wfc_core #(
    .WORD_LIMIT (WORD_LIMIT)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .en          (advance),
    .rx_byte     (in_byte),
    .frame_start (in_start),
    .word_count  (in_count),
    .res         (res)
  );

  // output register, loaded only with beats that carry a result
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && res.valid) begin
      data_word <= res.data_word;
      status    <= res.status;
      last      <= res.last;
    end
  end

endmodule
